// ----- rtl/core/cetb_pkg.sv -----
// Shared types and constants for the cell extent table builder.
package cetb_pkg;

    localparam int CELL_W      = 12;
    localparam int COUNT_W     = 13;
    localparam int IDX_W       = 17;
    localparam int MAX_CELLS   = 4096;

    localparam logic [COUNT_W-1:0] CELLS_LIMIT   = COUNT_W'(MAX_CELLS);
    localparam logic [IDX_W-1:0]   PARTICLE_SAT  = 17'h10000;

    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_PUSH   = 2'd1,
        KIND_FINISH = 2'd2,
        KIND_QUERY  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_SAT   = 2'd2
    } status_t;

    // One table entry: the run start sits in the low bits.
    typedef struct packed {
        logic [IDX_W-1:0] hi;
        logic [IDX_W-1:0] lo;
    } extent_t;

    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] addr;
        extent_t           data;
    } tbl_wr_t;

    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] addr;
    } tbl_rd_t;

endpackage

// ----- rtl/core/cell_extent_table_builder_core.sv -----
// Top level of the cell extent table builder: control, run tracking and result register.
//
// The block turns a sorted stream of cell ids into a table of half-open particle index
// ranges, one per cell, held in a single 4096-entry synchronous memory. Every input beat
// gives exactly one result beat. A push or a finish needs at most one table write. A
// query reads the table memory, whose read data is registered, and its result is loaded
// when the read data arrives. A start clears the entries of the cells in use with a
// sweep that writes one table entry per cycle; no input beat is taken during the sweep.
// After reset the same sweep runs over all 4096 entries before the input is first ready.
// The cell count register may be written at any time the block is idle, including
// during the sweep after reset. The result register lets a new beat enter in the cycle
// in which the previous result is taken.
module cell_extent_table_builder_core
    import cetb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: cell count.
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,
    // Input beats.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [11:0] cell_id, [15:12] zero
    input  logic [1:0]  s_tuser,    // [1:0] kind
    // Result beats.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [16:0] range_start, [33:17] range_end, [39:34] zero
    output logic [1:0]  m_tuser     // [1:0] status
);

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

    state_t             state_reg, state_next;
    logic [CELL_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [CELL_W-1:0]  clr_last_reg, clr_last_next;
    logic               pend_reg, pend_next;
    logic [COUNT_W-1:0] cell_count_reg, cell_count_next;
    logic [CELL_W-1:0]  cur_cell_reg, cur_cell_next;
    logic [IDX_W-1:0]   run_start_reg, run_start_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic               m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]   m_start_reg, m_start_next;
    logic [IDX_W-1:0]   m_end_reg, m_end_next;
    status_t            m_status_reg, m_status_next;

    tbl_wr_t            tbl_wr;
    tbl_rd_t            tbl_rd;
    extent_t            tbl_rd_data;

    logic               s_accept;
    logic               load;
    kind_t              kind;
    logic [CELL_W-1:0]  cell_id;
    logic [COUNT_W-1:0] cells_in_use;
    logic [COUNT_W-1:0] cells_less_one;
    logic               id_in_range;

    cetb_table u_table (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .rd      (tbl_rd),
        .rd_data (tbl_rd_data)
    );

    assign kind           = kind_t'(s_tuser);
    assign cell_id        = s_tdata[CELL_W-1:0];
    assign cells_in_use   = (cell_count_reg > CELLS_LIMIT) ? CELLS_LIMIT : cell_count_reg;
    assign cells_less_one = cells_in_use - COUNT_W'(1);
    assign id_in_range    = ({1'b0, cell_id} < cells_in_use);

    // New beats wait while the table is swept, while a query read is in flight, and while
    // a result is held that is not being taken.
    assign s_tready = (state_reg == ST_RUN) && !pend_reg && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        clr_last_next   = clr_last_reg;
        pend_next       = pend_reg;
        cell_count_next = cfg_wr_en ? cfg_wr_data : cell_count_reg;
        cur_cell_next   = cur_cell_reg;
        run_start_next  = run_start_reg;
        cnt_next        = cnt_reg;
        m_start_next    = m_start_reg;
        m_end_next      = m_end_reg;
        m_status_next   = m_status_reg;
        load            = 1'b0;
        tbl_wr          = '0;
        tbl_rd.en       = 1'b0;
        tbl_rd.addr     = cell_id;

        unique case (state_reg)
            ST_CLEAR: begin
                tbl_wr.en   = 1'b1;
                tbl_wr.addr = clr_addr_reg;
                if (clr_addr_reg == clr_last_reg) begin
                    state_next = ST_RUN;
                end else begin
                    clr_addr_next = clr_addr_reg + CELL_W'(1);
                end
            end
            ST_RUN: begin
                if (pend_reg) begin
                    // The query's table read has landed.
                    load          = 1'b1;
                    pend_next     = 1'b0;
                    m_start_next  = tbl_rd_data.lo;
                    m_end_next    = tbl_rd_data.hi;
                    m_status_next = STATUS_OK;
                end else if (s_accept) begin
                    m_start_next  = '0;
                    m_end_next    = '0;
                    m_status_next = STATUS_OK;
                    load          = 1'b1;
                    unique case (kind)
                        KIND_START: begin
                            cur_cell_next  = '0;
                            run_start_next = '0;
                            cnt_next       = '0;
                            if (cells_in_use != '0) begin
                                state_next    = ST_CLEAR;
                                clr_addr_next = '0;
                                clr_last_next = cells_less_one[CELL_W-1:0];
                            end
                        end
                        KIND_PUSH: begin
                            if (!id_in_range) begin
                                m_status_next = STATUS_RANGE;
                            end else if (cnt_reg >= PARTICLE_SAT) begin
                                m_status_next = STATUS_SAT;
                            end else begin
                                if (cell_id != cur_cell_reg) begin
                                    // A change of id closes the open run.
                                    tbl_wr.en      = 1'b1;
                                    tbl_wr.addr    = cur_cell_reg;
                                    tbl_wr.data.lo = run_start_reg;
                                    tbl_wr.data.hi = cnt_reg;
                                    run_start_next = cnt_reg;
                                    cur_cell_next  = cell_id;
                                end
                                cnt_next = cnt_reg + IDX_W'(1);
                            end
                        end
                        KIND_FINISH: begin
                            tbl_wr.en      = 1'b1;
                            tbl_wr.addr    = cur_cell_reg;
                            tbl_wr.data.lo = run_start_reg;
                            tbl_wr.data.hi = cnt_reg;
                        end
                        KIND_QUERY: begin
                            if (id_in_range) begin
                                // The result is loaded when the read data arrives.
                                load      = 1'b0;
                                tbl_rd.en = 1'b1;
                                pend_next = 1'b1;
                            end else begin
                                m_status_next = STATUS_RANGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            clr_last_reg   <= '1;
            pend_reg       <= 1'b0;
            cell_count_reg <= CELLS_LIMIT;
            cur_cell_reg   <= '0;
            run_start_reg  <= '0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            clr_last_reg   <= clr_last_next;
            pend_reg       <= pend_next;
            cell_count_reg <= cell_count_next;
            cur_cell_reg   <= cur_cell_next;
            run_start_reg  <= run_start_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
        end
        m_start_reg  <= m_start_next;
        m_end_reg    <= m_end_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_end_reg, m_start_reg};
    assign m_tuser  = m_status_reg;

`ifndef SYNTH
    // No beat enters while the table is being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input beat taken during table clear");

    // A query in flight always finds the result register free.
    a_pend_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !m_valid_reg)
        else $error("result register busy when query data arrives");

    // The particle counter never passes its bound.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= PARTICLE_SAT)
        else $error("particle counter beyond bound");

    // The open run never starts after the current particle count.
    a_run_order: assert property (@(posedge aclk) disable iff (!aresetn)
        run_start_reg <= cnt_reg)
        else $error("run start beyond particle counter");

    // A query read is followed by a result in the next cycle.
    a_query_result: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |=> m_valid_reg)
        else $error("query result not presented");
`endif

endmodule

// ----- rtl/core/cetb_table.sv -----
// Extent table memory: one write port and one read port with registered data.
module cetb_table
    import cetb_pkg::*;
(
    input  logic    aclk,
    input  tbl_wr_t wr,
    input  tbl_rd_t rd,
    output extent_t rd_data
);

    extent_t mem [MAX_CELLS];
    extent_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- tb/cell_extent_table_builder_core_test.sv -----
// Self-checking testbench for the cell extent table builder core.
`timescale 1ns / 1ps

module cell_extent_table_builder_core_test;
    import cetb_pkg::*;

    // The run is stopped as a failure if it reaches this many cycles, far more than the slowest
    // correct run takes: the clearing sweep after reset, at most a few hundred full-table
    // sweeps and about 67 thousand beats, most of them without idling.
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int MAX_IDLE      = 18;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 64;

    // One expected result beat.
    typedef struct {
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] last;
        status_t          status;
    } extent_result_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [12:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = KIND_START;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    // Our own copy of the block's state, updated as each input beat is accepted.
    logic [IDX_W-1:0]   extent_lo [0:MAX_CELLS-1];
    logic [IDX_W-1:0]   extent_hi [0:MAX_CELLS-1];
    logic [CELL_W-1:0]  open_cell;
    logic [IDX_W-1:0]   open_run_first;
    logic [IDX_W-1:0]   particles_pushed;
    logic [COUNT_W-1:0] cell_count_reg;

    // Results predicted but not yet seen on the result channel, oldest first.
    extent_result_t pending_extents[$];

    int  error_count   = 0;
    int  items_done    = 0;
    int  cycle_count   = 0;
    int  rx_hold_cycles = 0;
    bit  tx_idle       = 1'b1;
    bit  rx_idle       = 1'b1;

    cell_extent_table_builder_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("cell_extent_table_builder_core_test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------------------------

    function automatic void reset_table_model();
        for (int i = 0; i < MAX_CELLS; i++) begin
            extent_lo[i] = '0;
            extent_hi[i] = '0;
        end
        open_cell        = '0;
        open_run_first   = '0;
        particles_pushed = '0;
        cell_count_reg   = CELLS_LIMIT;
    endfunction

    // The register may hold more than the table has rows; anything above is clamped.
    function automatic int cells_in_use();
        return (cell_count_reg < CELLS_LIMIT) ? int'(cell_count_reg) : MAX_CELLS;
    endfunction

    // Writes the range of the open run into its cell's row. The open cell is always a
    // valid row index, even when the cell count has since been lowered below it.
    function automatic void close_open_run();
        extent_lo[open_cell] = open_run_first;
        extent_hi[open_cell] = particles_pushed;
    endfunction

    // Applies one accepted beat to the model and queues the result it must produce.
    function automatic void predict_extent(kind_t kind_sel, logic [CELL_W-1:0] id);
        extent_result_t res;
        int             n;
        n          = cells_in_use();
        res.first  = '0;
        res.last   = '0;
        res.status = STATUS_OK;
        case (kind_sel)
            KIND_START: begin
                // Only the rows in use are cleared; rows above keep stale ranges.
                for (int i = 0; i < n; i++) begin
                    extent_lo[i] = '0;
                    extent_hi[i] = '0;
                end
                open_cell        = '0;
                open_run_first   = '0;
                particles_pushed = '0;
            end
            KIND_PUSH: begin
                if (int'(id) >= n) begin
                    res.status = STATUS_RANGE;
                end else if (particles_pushed >= PARTICLE_SAT) begin
                    res.status = STATUS_SAT;
                end else begin
                    // A change of id closes the run behind it, sorted or not.
                    if (id != open_cell) begin
                        close_open_run();
                        open_run_first = particles_pushed;
                        open_cell      = id;
                    end
                    particles_pushed = particles_pushed + 1'b1;
                end
            end
            KIND_FINISH: begin
                close_open_run();
            end
            default: begin
                if (int'(id) >= n) begin
                    res.status = STATUS_RANGE;
                end else begin
                    res.first = extent_lo[id];
                    res.last  = extent_hi[id];
                end
            end
        endcase
        pending_extents.push_back(res);
        // Pushes that the block throws away do not count towards the random quota.
        if (!(kind_sel == KIND_PUSH && res.status != STATUS_OK)) begin
            items_done++;
        end
    endfunction

    // ------------------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------------------

    // Offers one beat after a random gap and returns at the edge where it is taken. The
    // valid is left high, so back-to-back beats need no second assignment in one step.
    task automatic send_beat(kind_t kind_sel, int id);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind_sel;
        s_tdata  <= {4'b0000, CELL_W'(id)};
        do @(posedge aclk); while (!s_tready);
        predict_extent(kind_sel, CELL_W'(id));
    endtask

    // Stops offering and waits until every predicted result has been taken. The wait starts
    // with a clock edge, so a following beat never lands in the same step as the lowering.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_extents.size() != 0);
    endtask

    // The register may only change while the block is idle: all results out and any
    // clearing sweep finished, which shows as the input being ready again.
    task automatic write_cell_count(logic [COUNT_W-1:0] value);
        wait_for_results();
        while (!s_tready) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en      <= 1'b0;
        cell_count_reg  = value;
    endtask

    // ------------------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------------------

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        error_count++;
        $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    // The receiver draws a stall before each beat, or takes a long hold when one has
    // been requested, and then checks the beat against the oldest prediction.
    initial begin : result_checker
        extent_result_t want;
        int             stall;
        forever begin
            stall = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (rx_hold_cycles > 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (pending_extents.size() == 0) begin
                error_count++;
                $display("%0t ns: result beat expected none, got start %0d end %0d status %0d",
                         $time, m_tdata[IDX_W-1:0], m_tdata[2*IDX_W-1:IDX_W], m_tuser);
            end else begin
                want = pending_extents.pop_front();
                if (m_tdata[IDX_W-1:0] !== want.first) begin
                    report_mismatch("range_start", want.first, m_tdata[IDX_W-1:0]);
                end
                if (m_tdata[2*IDX_W-1:IDX_W] !== want.last) begin
                    report_mismatch("range_end", want.last, m_tdata[2*IDX_W-1:IDX_W]);
                end
                if (m_tuser !== want.status) begin
                    report_mismatch("status", want.status, m_tuser);
                end
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // Sorted runs over eight cells, with an out-of-range push, queries at and past the
    // top of the table, a repeated finish, a push after finish that extends the open run
    // and an unsorted id that rewrites an earlier cell.
    task automatic test_directed_runs();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_cell_count(13'd8);
        send_beat(KIND_START, 12'hFFF);
        send_beat(KIND_QUERY, 0);
        send_beat(KIND_PUSH, 2);
        send_beat(KIND_PUSH, 2);
        send_beat(KIND_PUSH, 2);
        send_beat(KIND_PUSH, 5);
        send_beat(KIND_PUSH, 9);
        send_beat(KIND_PUSH, 7);
        send_beat(KIND_FINISH, 0);
        send_beat(KIND_QUERY, 2);
        send_beat(KIND_QUERY, 5);
        send_beat(KIND_QUERY, 7);
        send_beat(KIND_QUERY, 8);
        send_beat(KIND_QUERY, 12'hFFF);
        send_beat(KIND_FINISH, 12'hAAA);
        send_beat(KIND_PUSH, 7);
        send_beat(KIND_FINISH, 0);
        send_beat(KIND_QUERY, 7);
        send_beat(KIND_PUSH, 2);
        send_beat(KIND_FINISH, 0);
        send_beat(KIND_QUERY, 2);
        send_beat(KIND_QUERY, 0);
        wait_for_results();
    endtask

    // No cells at all, a single cell, and a register value above the table size.
    task automatic test_cell_count_extremes();
        write_cell_count(13'd0);
        send_beat(KIND_START, 0);
        send_beat(KIND_PUSH, 0);
        send_beat(KIND_QUERY, 0);
        send_beat(KIND_FINISH, 0);
        write_cell_count(13'd1);
        send_beat(KIND_START, 0);
        send_beat(KIND_PUSH, 0);
        send_beat(KIND_PUSH, 1);
        send_beat(KIND_FINISH, 0);
        send_beat(KIND_QUERY, 0);
        write_cell_count(13'h1FFF);
        send_beat(KIND_START, 0);
        send_beat(KIND_PUSH, 12'hFFF);
        send_beat(KIND_FINISH, 0);
        send_beat(KIND_QUERY, 12'hFFF);
        wait_for_results();
    endtask

    // The count is lowered below the open cell before the finish: the row is still
    // written, is hidden from queries, and survives a start that clears fewer rows.
    task automatic test_lowered_count();
        write_cell_count(13'd16);
        send_beat(KIND_START, 0);
        send_beat(KIND_PUSH, 10);
        write_cell_count(13'd4);
        send_beat(KIND_FINISH, 0);
        send_beat(KIND_QUERY, 10);
        send_beat(KIND_START, 0);
        write_cell_count(13'd16);
        send_beat(KIND_QUERY, 10);
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering beats,
    // so that the result register fills and the input stalls.
    task automatic test_backpressure();
        write_cell_count(13'd64);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_beat(KIND_START, 0);
        rx_hold_cycles = LONG_HOLD;
        for (int i = 0; i < 40; i++) begin
            send_beat(KIND_PUSH, i / 3);
        end
        send_beat(KIND_FINISH, 0);
        for (int i = 0; i < 14; i++) begin
            send_beat(KIND_QUERY, i);
        end
        wait_for_results();
    endtask

    // Mostly well-formed frames (start, sorted runs, finish, queries) with random
    // content, broken now and then by stray beats, plus some frames of pure noise.
    task automatic test_random_sequences();
        int target;
        int n;
        int first_id;
        int next_id;
        int runs;
        int len;
        int pick;
        target = items_done + RANDOM_ITEMS;
        while (items_done < target) begin
            if ($urandom_range(0, 2) == 0) begin
                pick = $urandom_range(0, 15);
                case (pick)
                    0:       write_cell_count(13'd0);
                    1:       write_cell_count(13'd1);
                    2:       write_cell_count(CELLS_LIMIT);
                    3:       write_cell_count(13'h1FFF);
                    4:       write_cell_count(COUNT_W'($urandom_range(65, 8190)));
                    default: write_cell_count(COUNT_W'($urandom_range(2, 64)));
                endcase
            end
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            n = cells_in_use();
            if ($urandom_range(0, 9) == 0) begin
                repeat (12) send_beat(kind_t'($urandom_range(0, 3)), $urandom_range(0, 4095));
            end else begin
                send_beat(KIND_START, $urandom_range(0, 4095));
                first_id = (n > 0) ? $urandom_range(0, (n - 1) / 2) : 0;
                next_id  = first_id;
                runs     = $urandom_range(1, 6);
                repeat (runs) begin
                    len = $urandom_range(1, 5);
                    repeat (len) begin
                        send_beat(KIND_PUSH, (n > 0) ? next_id : $urandom_range(0, 4095));
                        pick = $urandom_range(0, 19);
                        if (pick == 0 && n < MAX_CELLS) begin
                            send_beat(KIND_PUSH, $urandom_range(n, 4095));
                        end else if (pick == 1 && n > 0) begin
                            // An id out of order closes the run and reopens that cell.
                            send_beat(KIND_PUSH, $urandom_range(0, n - 1));
                        end else if (pick == 2) begin
                            send_beat(KIND_QUERY, $urandom_range(0, 4095));
                        end else if (pick == 3) begin
                            send_beat(KIND_FINISH, $urandom_range(0, 4095));
                        end else if (pick == 4) begin
                            wait_for_results();
                        end
                    end
                    if (n > 0) begin
                        next_id = next_id + $urandom_range(1, 3);
                        if (next_id > n - 1) begin
                            next_id = n - 1;
                        end
                    end
                end
                if ($urandom_range(0, 9) != 0) begin
                    send_beat(KIND_FINISH, $urandom_range(0, 4095));
                end
                if ($urandom_range(0, 4) == 0) begin
                    send_beat(KIND_FINISH, $urandom_range(0, 4095));
                end
                repeat ($urandom_range(2, 8)) begin
                    if (n == 0 || $urandom_range(0, 7) == 0) begin
                        send_beat(KIND_QUERY, $urandom_range(0, 4095));
                    end else begin
                        send_beat(KIND_QUERY, $urandom_range(first_id, next_id));
                    end
                end
            end
        end
        wait_for_results();
    endtask

    // Pushes the counter to its bound over the whole table, then checks that further
    // pushes are flagged and that the last range ends at the bound itself.
    task automatic test_counter_saturation();
        write_cell_count(CELLS_LIMIT);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_beat(KIND_START, 0);
        for (int i = 0; i < int'(PARTICLE_SAT); i++) begin
            send_beat(KIND_PUSH, i >> 4);
        end
        send_beat(KIND_PUSH, 12'hFFF);
        send_beat(KIND_PUSH, 0);
        send_beat(KIND_FINISH, 0);
        send_beat(KIND_QUERY, 12'hFFF);
        send_beat(KIND_QUERY, 0);
        send_beat(KIND_QUERY, 12'h800);
        wait_for_results();
    endtask

    initial begin
        reset_table_model();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_runs();
        test_cell_count_extremes();
        test_lowered_count();
        test_backpressure();
        test_random_sequences();
        test_counter_saturation();

        // Give a stray late beat time to show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("cell_extent_table_builder_core_test passed");
        end else begin
            $display("cell_extent_table_builder_core_test failed");
        end
        $finish;
    end

endmodule
